>>> rtl/tcp_congestion_and_rto_engine_assert.svh
// Assertion macros shared by the congestion and RTO engine.
`ifndef TCP_CONGESTION_AND_RTO_ENGINE_ASSERT_SVH
`define TCP_CONGESTION_AND_RTO_ENGINE_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define TCRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define TCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcre_pkg.sv
// Types, constants and helper functions of the congestion and RTO engine.
package tcre_pkg;

    // Congestion phase, one-hot inside the engine
    typedef enum logic [2:0] {
        PH_SLOW  = 3'b001,
        PH_AVOID = 3'b010,
        PH_RECOV = 3'b100
    } t_phase;

    // Phase codes as reported on the result word
    localparam logic [1:0] CP_SLOW  = 2'd0;
    localparam logic [1:0] CP_AVOID = 2'd1;
    localparam logic [1:0] CP_RECOV = 2'd2;

    // Event kinds
    localparam logic OP_ACK     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_INIT_SSTHRESH = 3'd0;
    localparam logic [2:0] CFG_MAX_WINDOW    = 3'd1;
    localparam logic [2:0] CFG_RTO_MIN       = 3'd2;
    localparam logic [2:0] CFG_RTO_MAX       = 3'd3;
    localparam logic [2:0] CFG_MAX_RETX      = 3'd4;

    // Reset values
    localparam logic [15:0] RST_SSTHRESH   = 16'd8;
    localparam logic [15:0] RST_MAX_WINDOW = 16'd16;
    localparam logic [23:0] RST_RTO_MIN    = 24'd1000000;
    localparam logic [23:0] RST_RTO_MAX    = 24'd3000000;
    localparam logic [7:0]  RST_MAX_RETX   = 8'd12;
    localparam logic [31:0] RST_SRTT_X8    = 32'd1312500;
    localparam logic [31:0] RST_RTTVAR     = 32'd1312500;
    localparam logic [23:0] RST_RTO        = 24'd1476562;

    localparam logic [1:0]  DUP_LIMIT      = 2'd3;
    localparam logic [15:0] WIN_MAX        = 16'hFFFF;

    // One input event word
    typedef struct packed {
        logic        op;
        logic [31:0] ack_num;
        logic [15:0] rwnd;
        logic [15:0] in_flight;
        logic [25:0] rtt_sample_us;
        logic        complete;
    } t_evt;

    // Congestion state as seen by the rest of the engine
    typedef struct packed {
        t_phase      phase;
        logic [15:0] window;
        logic [15:0] threshold;
        logic [1:0]  dup;
    } t_cong;

    // Saturating increment of a window
    function automatic logic [15:0] win_inc(input logic [15:0] w);
        return (w == WIN_MAX) ? w : w + 16'd1;
    endfunction

    // Saturating doubling of a window
    function automatic logic [15:0] win_dbl(input logic [15:0] w);
        return w[15] ? WIN_MAX : {w[14:0], 1'b0};
    endfunction

    // Half of a window, at least one
    function automatic logic [15:0] half_min1(input logic [15:0] w);
        return (w[15:1] == 15'd0) ? 16'd1 : {1'b0, w[15:1]};
    endfunction

    // RTO shifted left by the retry count, clamped to the maximum
    function automatic logic [23:0] backoff(input logic [23:0] rto,
                                            input logic [7:0]  retry,
                                            input logic [23:0] rto_max);
        logic [46:0] t;
        t = {23'd0, rto} << retry[4:0];
        if (rto == 24'd0) begin
            return 24'd0;
        end else if (retry >= 8'd24) begin
            return rto_max;
        end else if (t > {23'd0, rto_max}) begin
            return rto_max;
        end else begin
            return t[23:0];
        end
    endfunction

endpackage

>>> rtl/tcre_cong.sv
// Congestion window state machine: slow start, avoidance and fast recovery.
module tcre_cong import tcre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_evt        i_evt,
    output t_cong       o_cong,
    output logic [15:0] o_win_next
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_window, n_window;
    logic [15:0] r_threshold, n_threshold;
    logic [1:0]  r_dup, n_dup;
    logic [31:0] r_last_ack, n_last_ack;

    logic        w_is_dup;
    logic [15:0] w_dbl;

    assign w_is_dup = (i_evt.ack_num == r_last_ack);
    assign w_dbl    = win_dbl(r_window);

    // Next congestion state for the event in the input register
    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_threshold = r_threshold;
        n_dup       = r_dup;
        n_last_ack  = r_last_ack;
        if (i_evt.op == OP_TIMEOUT) begin
            n_threshold = half_min1(r_window);
            n_window    = 16'd1;
            n_dup       = 2'd0;
            n_phase     = PH_SLOW;
        end else begin
            if (!i_evt.complete) begin
                n_last_ack = i_evt.ack_num;
            end
            case (r_phase)
                PH_RECOV: begin
                    if (w_is_dup) begin
                        n_window = win_inc(r_window);
                    end else begin
                        n_phase  = PH_AVOID;
                        n_window = r_threshold;
                        n_dup    = 2'd0;
                    end
                end
                PH_SLOW: begin
                    if (!w_is_dup) begin
                        n_dup = 2'd0;
                        if (w_dbl >= r_threshold) begin
                            n_window = r_threshold;
                            n_phase  = PH_AVOID;
                        end else begin
                            n_window = w_dbl;
                        end
                    end
                end
                default: begin
                    if (!w_is_dup) begin
                        n_window = win_inc(r_window);
                        n_dup    = 2'd0;
                    end
                end
            endcase
            // third duplicate in slow start or avoidance enters fast recovery
            if (w_is_dup && r_phase != PH_RECOV) begin
                n_dup = (r_dup == DUP_LIMIT) ? r_dup : r_dup + 2'd1;
                if (n_dup == DUP_LIMIT) begin
                    n_phase     = PH_RECOV;
                    n_threshold = half_min1(r_window);
                    n_window    = half_min1(r_window);
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SLOW;
            r_window    <= 16'd1;
            r_threshold <= RST_SSTHRESH;
            r_dup       <= 2'd0;
            r_last_ack  <= 32'd0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_threshold <= n_threshold;
            r_dup       <= n_dup;
            r_last_ack  <= n_last_ack;
        end
    end

    assign o_cong.phase     = r_phase;
    assign o_cong.window    = r_window;
    assign o_cong.threshold = r_threshold;
    assign o_cong.dup       = r_dup;
    assign o_win_next       = n_window;

endmodule

>>> rtl/tcre_rtt.sv
// Jacobson RTT estimator and clamped retransmit timeout.
module tcre_rtt import tcre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_evt        i_evt,
    input  logic [23:0] i_rto_min,
    input  logic [23:0] i_rto_max,
    output logic [23:0] o_rto_us
);

    logic [31:0] r_srtt_x8, n_srtt_x8;
    logic [31:0] r_rttvar, n_rttvar;
    logic [23:0] r_rto, n_rto;
    logic        r_take;

    logic [28:0] w_srtt;
    logic [28:0] w_sample;
    logic [28:0] w_abs_d;
    logic [32:0] w_s_sum;
    logic [32:0] w_v_sum;
    logic [32:0] w_r_sum;
    logic        w_ack_open;

    assign w_srtt     = r_srtt_x8[31:3];
    assign w_sample   = {3'd0, i_evt.rtt_sample_us};
    assign w_ack_open = (i_evt.op == OP_ACK) && !i_evt.complete;

    // srtt8 + (sample - srtt8/8) and rttvar + |d| - rttvar/4, saturated
    always_comb begin
        w_abs_d   = (w_sample >= w_srtt) ? w_sample - w_srtt : w_srtt - w_sample;
        w_s_sum   = {1'b0, r_srtt_x8 - {3'd0, w_srtt}} + {7'd0, i_evt.rtt_sample_us};
        w_v_sum   = {1'b0, r_rttvar - {2'd0, r_rttvar[31:2]}} + {4'd0, w_abs_d};
        n_srtt_x8 = w_s_sum[32] ? 32'hFFFF_FFFF : w_s_sum[31:0];
        n_rttvar  = w_v_sum[32] ? 32'hFFFF_FFFF : w_v_sum[31:0];
        w_r_sum   = {4'd0, n_srtt_x8[31:3]} + {1'b0, n_rttvar};
        if (w_r_sum < {9'd0, i_rto_min}) begin
            n_rto = i_rto_min;
        end else if (w_r_sum > {9'd0, i_rto_max}) begin
            n_rto = i_rto_max;
        end else begin
            n_rto = w_r_sum[23:0];
        end
    end

    // Estimator registers; the first ack after a timeout skips its sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt_x8 <= RST_SRTT_X8;
            r_rttvar  <= RST_RTTVAR;
            r_rto     <= RST_RTO;
            r_take    <= 1'b1;
        end else if (i_adv) begin
            if (i_evt.op == OP_TIMEOUT) begin
                r_take <= 1'b0;
            end else if (w_ack_open) begin
                if (r_take) begin
                    r_srtt_x8 <= n_srtt_x8;
                    r_rttvar  <= n_rttvar;
                    r_rto     <= n_rto;
                end else begin
                    r_take <= 1'b1;
                end
            end
        end
    end

    assign o_rto_us = r_rto;

endmodule

>>> rtl/tcp_congestion_and_rto_engine.sv
// Top level of the congestion and retransmit timeout engine.
// One event word (ack or timer expiry) is accepted per clock while the result side
// keeps up. The word is first captured in an input register; when it moves on, the
// congestion machine and the RTT estimator update their state in one pass and the
// result register is loaded. Throughput is one word per cycle unless the result
// side stalls; the clock is set by the estimator path (two saturating adds, the
// RTO sum and its clamp compare). Stalls on the result side hold the state, so
// the window, threshold, timer and abort fields are read straight from it. Writes
// to the initial threshold index have no effect, since reset always loads a
// threshold of 8.
module tcp_congestion_and_rto_engine import tcre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [31:0] i_ack_num,
    input  logic [15:0] i_rwnd,
    input  logic [15:0] i_in_flight,
    input  logic [25:0] i_rtt_sample_us,
    input  logic        i_complete,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_cong_phase,
    output logic [15:0] o_cwnd_out,
    output logic [15:0] o_ssthresh_out,
    output logic [1:0]  o_dup_acks,
    output logic [15:0] o_send_count,
    output logic [23:0] o_timer_us,
    output logic        o_abort_flag,
    output logic        o_done_flag
);

`include "tcp_congestion_and_rto_engine_assert.svh"

    logic [15:0] r_max_window;
    logic [23:0] r_rto_min;
    logic [23:0] r_rto_max;
    logic [7:0]  r_max_retx;

    logic        r_in_valid;
    t_evt        r_evt;
    logic        r_out_valid;
    logic [15:0] r_send;
    logic        r_done;
    logic [7:0]  r_retry;

    logic        w_adv;
    t_cong       w_cong;
    logic [15:0] w_win_next;
    logic [23:0] w_rto;
    logic [15:0] w_space;
    logic [15:0] n_send;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_window <= RST_MAX_WINDOW;
            r_rto_min    <= RST_RTO_MIN;
            r_rto_max    <= RST_RTO_MAX;
            r_max_retx   <= RST_MAX_RETX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_WINDOW: r_max_window <= i_cfg_wdata[15:0];
                CFG_RTO_MIN:    r_rto_min    <= i_cfg_wdata;
                CFG_RTO_MAX:    r_rto_max    <= i_cfg_wdata;
                CFG_MAX_RETX:   r_max_retx   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: a word moves on when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_evt.op            <= i_op;
            r_evt.ack_num       <= i_ack_num;
            r_evt.rwnd          <= i_rwnd;
            r_evt.in_flight     <= i_in_flight;
            r_evt.rtt_sample_us <= i_rtt_sample_us;
            r_evt.complete      <= i_complete;
        end
    end

    tcre_cong u_cong (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_evt      (r_evt),
        .o_cong     (w_cong),
        .o_win_next (w_win_next)
    );

    tcre_rtt u_rtt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_evt     (r_evt),
        .i_rto_min (r_rto_min),
        .i_rto_max (r_rto_max),
        .o_rto_us  (w_rto)
    );

    // Send allowance: min of rwnd, new cwnd and free buffer space; zero on a timeout or a complete ack
    always_comb begin
        w_space = (r_evt.in_flight >= r_max_window) ? 16'd0
                                                    : r_max_window - r_evt.in_flight;
        n_send  = (r_evt.rwnd < w_win_next) ? r_evt.rwnd : w_win_next;
        if (w_space < n_send) begin
            n_send = w_space;
        end
        if (r_evt.op == OP_TIMEOUT || r_evt.complete) begin
            n_send = 16'd0;
        end
    end

    // Retry counter: timeouts count up (saturating), any ack clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= 8'd0;
        end else if (w_adv) begin
            if (r_evt.op == OP_TIMEOUT) begin
                r_retry <= (r_retry == 8'hFF) ? r_retry : r_retry + 8'd1;
            end else begin
                r_retry <= 8'd0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_send <= n_send;
            r_done <= (r_evt.op == OP_ACK) && r_evt.complete;
        end
    end

    // Result word: state fields come from the held engine state
    always_comb begin
        case (w_cong.phase)
            PH_SLOW:  o_cong_phase = CP_SLOW;
            PH_AVOID: o_cong_phase = CP_AVOID;
            PH_RECOV: o_cong_phase = CP_RECOV;
            default:  o_cong_phase = CP_SLOW;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_cwnd_out     = w_cong.window;
    assign o_ssthresh_out = w_cong.threshold;
    assign o_dup_acks     = w_cong.dup;
    assign o_send_count   = r_send;
    assign o_timer_us     = backoff(w_rto, r_retry, r_rto_max);
    assign o_abort_flag   = (r_retry >= r_max_retx);
    assign o_done_flag    = r_done;

    // Checks
    `TCRE_ASSERT_NOW(a_win_nonzero, i_clk, i_rst_n, 1'b1,
        (o_cwnd_out != 16'd0) && (o_ssthresh_out != 16'd0), "window or threshold is zero")
    `TCRE_ASSERT_NOW(a_recov_dup, i_clk, i_rst_n, w_cong.phase == PH_RECOV,
        o_dup_acks == DUP_LIMIT, "fast recovery without three duplicates")
    `TCRE_ASSERT_NEXT(a_timeout_result, i_clk, i_rst_n, w_adv && (r_evt.op == OP_TIMEOUT),
        (o_send_count == 16'd0) && (o_cwnd_out == 16'd1) && !o_done_flag,
        "timeout result not reset to one segment")
    `TCRE_ASSERT_NOW(a_timer_clamp, i_clk, i_rst_n, o_out_valid,
        o_timer_us <= r_rto_max, "timer above configured maximum")

endmodule
